// ===== hw/rtl/hrfm_pkg.sv =====
// Shared definitions for the hysteresis rod flux model: constants, register
// indexes, the CORDIC status struct, the arctangent step table and saturation.
// No dependencies.
package hrfm_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 24;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CY_W = 61;

  typedef enum logic [1:0] {
    REG_SLOPE_TOL = 2'd0,
    REG_COERCIVE  = 2'd1,
    REG_GAIN      = 2'd2,
    REG_SCALE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // Arctangent of 2^-i in Q.32.
  function automatic logic [31:0] atan_step(input logic [5:0] i);
    logic [31:0] v;
    case (i)
      6'd0:    v = 32'd3373259426;
      6'd1:    v = 32'd1991351318;
      6'd2:    v = 32'd1052175346;
      6'd3:    v = 32'd534100635;
      6'd4:    v = 32'd268086748;
      6'd5:    v = 32'd134174063;
      6'd6:    v = 32'd67103403;
      6'd7:    v = 32'd33553749;
      6'd8:    v = 32'd16777131;
      6'd9:    v = 32'd8388597;
      6'd10:   v = 32'd4194303;
      default: v = (i < 6'd32) ? (32'd1 << (6'd32 - i)) : 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hrfm_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on hrfm_pkg for operand and product widths.
module hrfm_mul import hrfm_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// ===== hw/rtl/hrfm_cordic.sv =====
// Vectoring CORDIC that rotates one step per cycle and accumulates the angle.
// Depends on hrfm_pkg for the angle table and the status struct.
module hrfm_cordic import hrfm_pkg::*; #(
  parameter int ITER = CORDIC_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [CY_W-1:0]     cy_init,
  output cordic_stat_t        stat,
  output logic signed [35:0]  angle
);

  localparam int CNT_W = $clog2(ITER + 1);

  logic signed [63:0] cx_r, cy_r;
  logic signed [35:0] cz_r;
  logic [CNT_W-1:0]   iter_r;
  logic               busy_r, done_r;
  logic signed [63:0] dx, dy;
  logic signed [35:0] step;
  logic               last;

  assign dx   = cy_r >>> iter_r;
  assign dy   = cx_r >>> iter_r;
  assign step = {4'b0, atan_step(6'(iter_r))};
  assign last = (iter_r == CNT_W'(ITER - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx_r <= 64'sd274877906944;
      cy_r <= signed'({3'b0, cy_init});
      cz_r <= '0;
    end else if (busy_r) begin
      if (!cy_r[63]) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + step;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - step;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign angle     = cz_r;

endmodule

// ===== hw/rtl/hysteresis_rod_flux_model.sv =====
// Top level of the hysteresis rod flux model: sequencer, datapath registers,
// configuration registers. Depends on hrfm_pkg, hrfm_mul and hrfm_cordic.
//
// Each request carries an applied field vector (Q16.16) and a rod direction
// (Q1.14). The block projects the field onto the rod, picks the rising or the
// falling branch of the hysteresis loop by comparing the projection with the
// previous one against a deadband, and returns the flux
// scale * atan(gain * (h -/+ hc)) together with the flux times each direction
// component, all saturated Q16.16. One request is worked on at a time: the
// next request is taken only after the result is loaded into the output
// register. The CORDIC unit steps once per cycle; a single shared 33 x 33
// multiplier handles the dot product, the arctangent argument, the scaling
// and the three direction products in turn. When the arctangent argument is
// zero the CORDIC pass is skipped. A finished result waits in the output
// register while the block already accepts the next request; if that result
// is still unread when the next one is ready, the block holds in its last
// step until the output register drains.
// Configuration writes are always ready and must only be issued while idle.
module hysteresis_rod_flux_model import hrfm_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_field_x,
  input  logic signed [31:0] in_field_y,
  input  logic signed [31:0] in_field_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_flux,
  output logic               out_slope_up,
  output logic signed [31:0] out_flux_x,
  output logic signed [31:0] out_flux_y,
  output logic signed [31:0] out_flux_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DOT    = 10'b0000000010,
    ST_PROJ   = 10'b0000000100,
    ST_ARG    = 10'b0000001000,
    ST_SAT    = 10'b0000010000,
    ST_CORDIC = 10'b0000100000,
    ST_SCALE  = 10'b0001000000,
    ST_FLUX   = 10'b0010000000,
    ST_DIR    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [30:0] tol_r, hc_r, scale_r;
  logic [31:0] gain_r;

  // Request and working registers.
  logic signed [31:0] fx_r, fy_r, fz_r;
  logic signed [15:0] dx_r, dy_r, dz_r;
  logic [1:0]         cnt_r, cnt_nxt;
  logic signed [48:0] acc_r, acc_nxt;
  logic signed [31:0] h_r, h_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic               rising_r, rising_nxt;
  logic               neg_r, neg_nxt;
  logic               big_r, big_nxt;
  logic signed [31:0] ang_r, ang_nxt;
  logic signed [31:0] fl_r, fl_nxt;
  logic signed [31:0] fdx_r, fdy_r, fdz_r;
  logic signed [31:0] fdx_nxt, fdy_nxt, fdz_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_flux_r, out_fx_r, out_fy_r, out_fz_r;
  logic               out_slope_r;
  logic               load_out;

  // Shared units.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic                     cordic_start;
  logic [CY_W-1:0]          cordic_cy;
  cordic_stat_t             cordic_stat;
  logic signed [35:0]       cordic_angle;

  // Combinational helpers.
  logic signed [31:0] sel_f;
  logic signed [15:0] sel_d;
  logic signed [67:0] prod_ext;
  logic signed [67:0] proj_rnd;
  logic signed [31:0] proj_h;
  logic signed [33:0] diff;
  logic signed [33:0] tol_s;
  logic signed [33:0] arg_x;
  logic [33:0]        arg_abs;
  logic [63:0]        p_raw, p_sat;
  logic signed [36:0] ang_rnd;
  logic signed [31:0] ang_mag;
  logic signed [31:0] dir_prod;

  hrfm_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  hrfm_cordic #(
    .ITER (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .cy_init (cordic_cy),
    .stat    (cordic_stat),
    .angle   (cordic_angle)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= '0;
      hc_r    <= '0;
      gain_r  <= '0;
      scale_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLOPE_TOL: tol_r   <= cfg_wdata[30:0];
        REG_COERCIVE:  hc_r    <= cfg_wdata[30:0];
        REG_GAIN:      gain_r  <= cfg_wdata;
        REG_SCALE:     scale_r <= cfg_wdata[30:0];
      endcase
    end
  end

  // Operand selection for the dot product and the direction products.
  always_comb begin
    case (cnt_r)
      2'd1: begin
        sel_f = fy_r;
        sel_d = dy_r;
      end
      2'd2: begin
        sel_f = fz_r;
        sel_d = dz_r;
      end
      default: begin
        sel_f = fx_r;
        sel_d = dx_r;
      end
    endcase
  end

  // Datapath arithmetic shared by the states below.
  always_comb begin
    prod_ext = {{(68 - PROD_W){prod_r[PROD_W-1]}}, prod_r};

    // Projection rounded half up from Q.30 to Q16.16.
    proj_rnd = {{19{acc_r[48]}}, acc_r} + 68'sd8192;
    proj_h   = sat32(proj_rnd >>> 14);
    diff     = 34'(proj_h) - 34'(prev_r);
    tol_s    = signed'({3'b0, tol_r});

    // Offset field on the current branch, split into sign and magnitude.
    arg_x   = rising_r ? (34'(h_r) - signed'({3'b0, hc_r}))
                       : (34'(h_r) + signed'({3'b0, hc_r}));
    arg_abs = arg_x[33] ? 34'(-arg_x) : 34'(arg_x);

    // Arctangent argument, clamped at 2^62.
    p_raw = big_r ? {gain_r, 32'b0} : prod_r[63:0];
    p_sat = (p_raw > (64'd1 << 62)) ? (64'd1 << 62) : p_raw;

    // Angle rounded half up from Q.32 to Q2.30.
    ang_rnd = {cordic_angle[35], cordic_angle} + 37'sd2;
    ang_mag = ang_rnd[33:2];

    dir_prod = sat32((prod_ext + 68'sd8192) >>> 14);
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_DOT: begin
        mul_a = MUL_W'(sel_f);
        mul_b = MUL_W'(sel_d);
      end
      ST_ARG: begin
        mul_a = signed'({1'b0, arg_abs[31:0]});
        mul_b = signed'({1'b0, gain_r});
      end
      ST_SCALE: begin
        mul_a = signed'({2'b0, scale_r});
        mul_b = MUL_W'(ang_r);
      end
      ST_DIR: begin
        mul_a = MUL_W'(fl_r);
        mul_b = MUL_W'(sel_d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    h_nxt        = h_r;
    prev_nxt     = prev_r;
    rising_nxt   = rising_r;
    neg_nxt      = neg_r;
    big_nxt      = big_r;
    ang_nxt      = ang_r;
    fl_nxt       = fl_r;
    fdx_nxt      = fdx_r;
    fdy_nxt      = fdy_r;
    fdz_nxt      = fdz_r;
    cordic_start = 1'b0;
    cordic_cy    = p_sat[62:2];
    load_out     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DOT;
          cnt_nxt   = '0;
          acc_nxt   = '0;
        end
      end
      ST_DOT: begin
        // Product of the previous component arrives in the cycle after issue.
        if (cnt_r != 2'd0) begin
          acc_nxt = acc_r + 49'(signed'(prod_r[47:0]));
        end
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_PROJ;
        end
      end
      ST_PROJ: begin
        // A change of exactly the tolerance keeps the branch.
        if (diff < -tol_s) begin
          rising_nxt = 1'b0;
        end else if (diff > tol_s) begin
          rising_nxt = 1'b1;
        end
        h_nxt     = proj_h;
        prev_nxt  = proj_h;
        state_nxt = ST_ARG;
      end
      ST_ARG: begin
        neg_nxt   = arg_x[33];
        big_nxt   = |arg_abs[33:32];
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (p_sat == 64'd0) begin
          ang_nxt   = '0;
          state_nxt = ST_SCALE;
        end else begin
          cordic_start = 1'b1;
          state_nxt    = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cordic_stat.done) begin
          ang_nxt   = neg_r ? -ang_mag : ang_mag;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_nxt = ST_FLUX;
      end
      ST_FLUX: begin
        fl_nxt    = sat32((prod_ext + 68'sd536870912) >>> 30);
        cnt_nxt   = '0;
        state_nxt = ST_DIR;
      end
      ST_DIR: begin
        case (cnt_r)
          2'd1:    fdx_nxt = dir_prod;
          2'd2:    fdy_nxt = dir_prod;
          2'd3:    fdz_nxt = dir_prod;
          default: fdx_nxt = fdx_r;
        endcase
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      prev_r      <= '0;
      rising_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      rising_r    <= rising_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      fx_r <= in_field_x;
      fy_r <= in_field_y;
      fz_r <= in_field_z;
      dx_r <= in_dir_x;
      dy_r <= in_dir_y;
      dz_r <= in_dir_z;
    end
    acc_r <= acc_nxt;
    h_r   <= h_nxt;
    neg_r <= neg_nxt;
    big_r <= big_nxt;
    ang_r <= ang_nxt;
    fl_r  <= fl_nxt;
    fdx_r <= fdx_nxt;
    fdy_r <= fdy_nxt;
    fdz_r <= fdz_nxt;
    if (load_out) begin
      out_flux_r  <= fl_r;
      out_slope_r <= rising_r;
      out_fx_r    <= fdx_r;
      out_fy_r    <= fdy_r;
      out_fz_r    <= fdz_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_flux     = out_flux_r;
  assign out_slope_up = out_slope_r;
  assign out_flux_x   = out_fx_r;
  assign out_flux_y   = out_fy_r;
  assign out_flux_z   = out_fz_r;

`ifndef SYNTHESIS
  // A started CORDIC pass must be running in the following cycle.
  a_cordic_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_start |=> cordic_stat.busy)
    else $error("CORDIC did not start");

  // The CORDIC finishes only while the sequencer waits for it.
  a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_stat.done |-> (state_r == ST_CORDIC))
    else $error("CORDIC finished outside its wait state");

  // The branch bit only moves when a projection is evaluated.
  a_branch_update: assert property (@(posedge clk) disable iff (!rst_n)
    (rising_r != $past(rising_r)) |-> ($past(state_r) == ST_PROJ))
    else $error("branch changed outside projection step");

  // A result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");
`endif

endmodule
